@@ rtl/dq_pkg.sv @@
`timescale 1ns / 1ps

package dq_pkg;

  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_t;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 11;

endpackage

@@ rtl/dq_ram.sv @@
`timescale 1ns / 1ps

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/double_ended_queue.sv @@
`timescale 1ns / 1ps

// double-ended queue of signed 32-bit values in a ring held in one RAM.
// input channel: in_kind and in_value are taken at a rising edge with start
//   high and busy low; busy is always low, so an operation may be issued
//   every cycle.
// result channel: out_valid strobes for exactly one cycle, in the cycle after
//   the operation was taken, with out_accepted, out_popped_value,
//   out_entry_count and out_is_empty. the receiver cannot stall, so results
//   simply follow the issue order at one per cycle.
// throughput is 1 operation per cycle: each accepted operation makes a single
//   RAM access (write for a push, read for a pop) whose registered read data
//   arrives with the result strobe.
// a pop on an empty queue and a push on a full queue are refused and leave
//   the state alone.
// reset (synchronous, rst_n low) clears the front index, the count and the
//   result strobe; RAM contents are not cleared and need no clearing pass.
module double_ended_queue #(
  parameter int DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  dq_pkg::kind_t                in_kind,
  input  logic signed [31:0]           in_value,
  output logic                         out_valid,
  output logic                         out_accepted,
  output logic signed [31:0]           out_popped_value,
  output logic [10:0]                  out_entry_count,
  output logic                         out_is_empty
);

  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW:0] DEPTH_S = (CW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          valid_r, valid_nxt;
  logic          acc_r, acc_nxt;
  logic          pop_r, pop_nxt;

  logic          take;
  logic          is_push;
  logic          full;
  logic          empty;
  logic [CW:0]   back_sum;
  logic [CW:0]   back_wrap;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;
  logic [AW-1:0] addr;
  logic          ram_en;
  logic          ram_we;
  logic [VALUE_W-1:0] rdata;
  logic [CW+10:0] count_ext;

  assign busy    = 1'b0;
  assign take    = start && !busy;
  assign is_push = (in_kind == KIND_PUSH_FRONT) || (in_kind == KIND_PUSH_BACK);
  assign full    = ({1'b0, count_r} == DEPTH_S);
  assign empty   = (count_r == '0);

  // back position: front + count for push back, front + count - 1 for pop back
  always_comb begin
    if (in_kind == KIND_PUSH_BACK) begin
      back_sum = {1'b0, {(CW - AW){1'b0}}, front_r} + {1'b0, count_r};
    end else begin
      back_sum = {1'b0, {(CW - AW){1'b0}}, front_r} + {1'b0, count_r} - 1'b1;
    end
    back_wrap = (back_sum >= DEPTH_S) ? back_sum - DEPTH_S : back_sum;
  end

  assign front_dec = (front_r == '0) ? LAST_IDX : front_r - 1'b1;
  assign front_inc = (front_r == LAST_IDX) ? '0 : front_r + 1'b1;

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    acc_nxt   = 1'b0;
    pop_nxt   = 1'b0;
    valid_nxt = take;
    addr      = back_wrap[AW-1:0];
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    if (take) begin
      case (in_kind)
        KIND_PUSH_FRONT: begin
          if (!full) begin
            front_nxt = front_dec;
            addr      = front_dec;
            count_nxt = count_r + 1'b1;
            acc_nxt   = 1'b1;
            ram_en    = 1'b1;
            ram_we    = 1'b1;
          end
        end
        KIND_PUSH_BACK: begin
          if (!full) begin
            count_nxt = count_r + 1'b1;
            acc_nxt   = 1'b1;
            ram_en    = 1'b1;
            ram_we    = 1'b1;
          end
        end
        KIND_POP_FRONT: begin
          if (!empty) begin
            addr      = front_r;
            front_nxt = front_inc;
            count_nxt = count_r - 1'b1;
            acc_nxt   = 1'b1;
            pop_nxt   = 1'b1;
            ram_en    = 1'b1;
          end
        end
        KIND_POP_BACK: begin
          if (!empty) begin
            count_nxt = count_r - 1'b1;
            acc_nxt   = 1'b1;
            pop_nxt   = 1'b1;
            ram_en    = 1'b1;
          end
        end
        default: begin
          acc_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      valid_r <= 1'b0;
      acc_r   <= 1'b0;
      pop_r   <= 1'b0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
      acc_r   <= acc_nxt;
      pop_r   <= pop_nxt;
    end
  end

  dq_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we && is_push),
    .addr (addr),
    .wdata(in_value),
    .rdata(rdata)
  );

  // count after the transaction is already in count_r when the result shows
  assign count_ext        = {11'b0, count_r};
  assign out_valid        = valid_r;
  assign out_accepted     = acc_r;
  assign out_popped_value = pop_r ? rdata : '0;
  assign out_entry_count  = count_ext[10:0];
  assign out_is_empty     = (count_r == '0);

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import dq_pkg::*;

  localparam int DEPTH = 1024;

  typedef struct {
    logic               accepted;
    logic signed [31:0] popped;
    logic [10:0]        count;
    logic               is_empty;
  } deque_result_t;

  logic               clk;
  logic               rst_n    = 1'b0;
  logic               start    = 1'b0;
  kind_t              in_kind  = KIND_PUSH_BACK;
  logic signed [31:0] in_value = '0;
  logic               busy;
  logic               out_valid;
  logic               out_accepted;
  logic signed [31:0] out_popped_value;
  logic [10:0]        out_entry_count;
  logic               out_is_empty;

  // shadow deque state, updated on every accepted transaction
  logic signed [31:0] shadow_ring [DEPTH];
  int unsigned        shadow_front = 0;
  int unsigned        shadow_count = 0;

  deque_result_t      pending_results[$];
  int                 err_count   = 0;
  int                 ops_sent    = 0;
  int                 n_checked   = 0;
  int                 n_refused   = 0;
  int                 max_level   = 0;

  double_ended_queue #(.DEPTH(DEPTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_accepted     (out_accepted),
    .out_popped_value (out_popped_value),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic deque_result_t apply_deque_op(kind_t k, logic signed [31:0] v);
    deque_result_t r;
    r.accepted = 1'b0;
    r.popped   = '0;
    case (k)
      KIND_PUSH_FRONT: begin
        if (shadow_count < DEPTH) begin
          shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
          shadow_ring[shadow_front] = v;
          shadow_count++;
          r.accepted = 1'b1;
        end
      end
      KIND_PUSH_BACK: begin
        if (shadow_count < DEPTH) begin
          shadow_ring[(shadow_front + shadow_count) % DEPTH] = v;
          shadow_count++;
          r.accepted = 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (shadow_count > 0) begin
          r.popped = shadow_ring[shadow_front];
          shadow_front = (shadow_front + 1) % DEPTH;
          shadow_count--;
          r.accepted = 1'b1;
        end
      end
      default: begin
        if (shadow_count > 0) begin
          r.popped = shadow_ring[(shadow_front + shadow_count - 1) % DEPTH];
          shadow_count--;
          r.accepted = 1'b1;
        end
      end
    endcase
    r.count    = shadow_count[10:0];
    r.is_empty = (shadow_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic signed [31:0] exp_v,
                                 logic signed [31:0] act_v);
    err_count++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
  endtask

  // prediction first, so the ordering holds even for a same-edge result
  always @(posedge clk) begin
    deque_result_t exp_r;
    if (rst_n && start && !busy) begin
      exp_r = apply_deque_op(in_kind, in_value);
      pending_results.push_back(exp_r);
      if (!exp_r.accepted) n_refused++;
      if (shadow_count > max_level) max_level = shadow_count;
    end
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result, expected none, got count %0d", $time,
                 out_entry_count);
      end else begin
        exp_r = pending_results.pop_front();
        n_checked++;
        if (out_accepted !== exp_r.accepted)
          report_mismatch("accepted", exp_r.accepted, out_accepted);
        if (out_popped_value !== exp_r.popped)
          report_mismatch("popped_value", exp_r.popped, out_popped_value);
        if (out_entry_count !== exp_r.count)
          report_mismatch("entry_count", exp_r.count, out_entry_count);
        if (out_is_empty !== exp_r.is_empty)
          report_mismatch("is_empty", exp_r.is_empty, out_is_empty);
      end
    end
  end

  task automatic send_op(kind_t k, logic signed [31:0] v, int gap_pct);
    logic was_busy;
    start    <= 1'b1;
    in_kind  <= k;
    in_value <= v;
    do begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
    end while (was_busy);
    ops_sent++;
    // each following cycle is idle with probability gap_pct percent
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_ops(int n, int gap_pct, int pop_pct);
    kind_t k;
    repeat (n) begin
      if ($urandom_range(99) < pop_pct)
        k = $urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK;
      else
        k = $urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
      send_op(k, pick_value(), gap_pct);
      if ($urandom_range(63) == 0) wait_idle();
    end
    wait_idle();
  endtask

  task automatic test_directed();
    // refused pops straight after reset
    send_op(KIND_POP_FRONT, 32'sd5, 0);
    send_op(KIND_POP_BACK, 32'sd6, 0);
    // first push at the front wraps the front index below zero
    send_op(KIND_PUSH_FRONT, 32'sh7fff_ffff, 0);
    send_op(KIND_PUSH_BACK, 32'sh8000_0000, 0);
    send_op(KIND_PUSH_FRONT, 32'sd0, 0);
    send_op(KIND_PUSH_BACK, -32'sd1, 0);
    send_op(KIND_PUSH_FRONT, 32'sh5555_5555, 0);
    send_op(KIND_PUSH_BACK, 32'shaaaa_aaaa, 0);
    send_op(KIND_POP_BACK, 32'sd0, 0);
    send_op(KIND_POP_FRONT, -32'sd1, 0);
    send_op(KIND_POP_FRONT, 32'sd0, 0);
    send_op(KIND_POP_BACK, 32'sd0, 0);
    send_op(KIND_POP_FRONT, 32'sd0, 0);
    send_op(KIND_POP_BACK, 32'sd0, 0);
    send_op(KIND_POP_BACK, 32'sd0, 0);
    send_op(KIND_POP_FRONT, 32'sd0, 0);
    send_op(KIND_PUSH_BACK, 32'sd1, 0);
    send_op(KIND_POP_FRONT, 32'sd0, 0);
    send_op(KIND_PUSH_FRONT, 32'sd2, 0);
    send_op(KIND_POP_BACK, 32'sd0, 0);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    random_ops(250, 0, 45);
  endtask

  task automatic test_fill_to_full();
    int n_push;
    wait_idle();
    // a few extra pushes land on a full queue and must be refused
    n_push = DEPTH - shadow_count + 4;
    repeat (n_push)
      send_op($urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, pick_value(), 47);
    wait_idle();
  endtask

  task automatic test_near_full();
    random_ops(80, 34, 50);
  endtask

  task automatic test_drain();
    random_ops(250, 47, 50);
    random_ops(300, 34, 75);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_traffic();
    test_fill_to_full();
    test_near_full();
    test_drain();
    wait_idle();
    $display("ran %0d transactions, %0d results checked, %0d refused", ops_sent,
             n_checked, n_refused);
    $display("queue level reached %0d of %0d entries, wrap and full cases included",
             max_level, DEPTH);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
